// ===== sv/segmented_sieve_marker_top_defines.svh =====
// Assertion macros used by the checker file of the sieve block.
`ifndef SEGMENTED_SIEVE_MARKER_TOP_DEFINES_SVH
`define SEGMENTED_SIEVE_MARKER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("sieve marker check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("sieve marker check failed");

`endif

// ===== sv/ssm_pkg.sv =====
`default_nettype none

package ssm_pkg;

	// Field widths.
	localparam int TOP_W  = 31;
	localparam int LEN_W  = 10;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;
	// A sieving prime whose square stays within TOP_W bits fits in this many bits.
	localparam int ROOT_W = 16;

	// Default sizes.
	localparam int SEG_SIZE_DEF = 1024;
	localparam int MID_DEPTH    = 4;
	localparam int OUT_DEPTH    = 2;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TOP = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEN = 1'd1;

	// Register reset values.
	localparam logic [TOP_W-1:0] TOP_RST = 31'd1023;
	localparam logic [LEN_W-1:0] LEN_RST = 10'd1023;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STRIKE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

	// Operations after classification by the front end.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_INIT,
		OP_STRIKE,
		OP_IGNORE,
		OP_QUERY,
		OP_BADQ
	} op_t;

	// Work item handed from the front end to the back end.
	typedef struct packed {
		op_t              op;
		logic [TOP_W-1:0] operand;
	} work_t;

	// Result item.
	typedef struct packed {
		logic [TOP_W-1:0]  number;
		logic              is_prime;
		logic [STAT_W-1:0] status;
	} res_t;

	// Window geometry derived from the configuration registers.
	typedef struct packed {
		logic [TOP_W-1:0] top;
		logic [TOP_W-1:0] low;
		logic [TOP_W-1:0] span_m1;
	} win_t;

endpackage

`default_nettype wire

// ===== sv/segmented_sieve_marker_top.sv =====
// Channel   Direction  Handshake               Payload
// input     in         push / full             cmd, operand
// result    out        pop / empty             number, is_prime, status
// config    in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Each item gives exactly one result. A query reads one mark. A strike runs
// the 31-step remainder unit, then walks the struck entries of the window.
// Init writes every entry of the mark store, one mark store write per cycle.
// Ignored, out-of-range and unused commands go straight to the result.
// Reset clears the control state; queries report no prime until the first init.
// The input stage and a small queue keep taking items while the sequencer is
// busy or the result queue is full.
`default_nettype none

module segmented_sieve_marker_top #(
	parameter int SEG_SIZE = ssm_pkg::SEG_SIZE_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [ssm_pkg::CMD_W-1:0]     cmd,
	input  wire logic [ssm_pkg::TOP_W-1:0]     operand,
	input  wire logic                          pop,
	output logic                               empty,
	output logic [ssm_pkg::TOP_W-1:0]          number,
	output logic                               is_prime,
	output logic [ssm_pkg::STAT_W-1:0]         status,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ssm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ssm_pkg::TOP_W-1:0]     cfg_data
);

	import ssm_pkg::*;

	logic [TOP_W-1:0] seg_top_q;
	logic [LEN_W-1:0] seg_len_q;
	win_t             win_q;
	logic             len_over;
	logic             mid_push;
	work_t            mid_wdata;
	logic             mid_full;
	logic             mid_pop;
	work_t            mid_rdata;
	logic             mid_empty;
	logic             res_push;
	res_t             res_wdata;
	logic             res_full;
	res_t             res_rdata;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_top_q <= TOP_RST;
			seg_len_q <= LEN_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TOP: seg_top_q <= cfg_data;
				default: seg_len_q <= cfg_data[LEN_W-1:0];
			endcase
		end
	end

	// Window geometry; a length past the top pins the low end at zero.
	assign len_over = TOP_W'(seg_len_q) > seg_top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.top     <= TOP_RST;
			win_q.low     <= TOP_RST - TOP_W'(LEN_RST);
			win_q.span_m1 <= TOP_W'(LEN_RST);
		end else begin
			win_q.top     <= seg_top_q;
			win_q.low     <= len_over ? '0 : seg_top_q - TOP_W'(seg_len_q);
			win_q.span_m1 <= len_over ? seg_top_q : TOP_W'(seg_len_q);
		end
	end

	ssm_front #(
		.SEG_SIZE (SEG_SIZE)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.cmd     (cmd),
		.operand (operand),
		.win     (win_q),
		.q_push  (mid_push),
		.q_data  (mid_wdata),
		.q_full  (mid_full)
	);

	ssm_queue #(
		.W     ($bits(work_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	ssm_back #(
		.SEG_SIZE (SEG_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.win      (win_q),
		.q_empty  (mid_empty),
		.q_data   (mid_rdata),
		.q_pop    (mid_pop),
		.out_full (res_full),
		.out_push (res_push),
		.out_data (res_wdata)
	);

	ssm_queue #(
		.W     ($bits(res_t)),
		.DEPTH (OUT_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wdata),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_rdata),
		.empty   (empty)
	);

	assign number   = res_rdata.number;
	assign is_prime = res_rdata.is_prime;
	assign status   = res_rdata.status;

endmodule

`default_nettype wire

// ===== sv/ssm_queue.sv =====
`default_nettype none

module ssm_queue #(
	parameter int W     = $bits(ssm_pkg::work_t),
	parameter int DEPTH = ssm_pkg::MID_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	output logic              full,
	input  wire logic         rd_en,
	output logic [W-1:0]      rd_data,
	output logic              empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [W-1:0]  slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   fill_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (fill_q == (AW + 1)'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== sv/ssm_front.sv =====
`default_nettype none

module ssm_front #(
	parameter int SEG_SIZE = ssm_pkg::SEG_SIZE_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [ssm_pkg::CMD_W-1:0] cmd,
	input  wire logic [ssm_pkg::TOP_W-1:0] operand,
	input  wire ssm_pkg::win_t             win,
	output logic                           q_push,
	output ssm_pkg::work_t                 q_data,
	input  wire logic                      q_full
);

	import ssm_pkg::*;

	localparam logic [31:0] SEG_SIZE_W = 32'(SEG_SIZE);

	logic                 v_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [TOP_W-1:0]     opnd_s1;
	logic [2*ROOT_W-1:0]  sq_s1;
	logic                 hi_s1;
	logic                 in_acc;
	logic                 bad_prime;
	logic                 bad_offset;

	assign full   = v_s1 && q_full;
	assign in_acc = push && !full;
	assign q_push = v_s1 && !q_full;

	// Stage valid: filled on accept, emptied when the queue takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	// Capture the item and the square of the low half of the operand.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1  <= cmd;
			opnd_s1 <= operand;
			sq_s1   <= (2*ROOT_W)'(operand[ROOT_W-1:0]) * (2*ROOT_W)'(operand[ROOT_W-1:0]);
			hi_s1   <= |operand[TOP_W-1:ROOT_W];
		end
	end

	// A prime is ignored below two or when its square passes the top.
	assign bad_prime  = (opnd_s1 < TOP_W'(2)) || hi_s1 || (sq_s1 > {1'b0, win.top});
	assign bad_offset = (opnd_s1 > win.span_m1) || ({1'b0, opnd_s1} >= SEG_SIZE_W);

	// Classify the staged item.
	always_comb begin
		q_data.operand = opnd_s1;
		unique case (cmd_s1)
			CMD_INIT: begin
				q_data.op = OP_INIT;
			end
			CMD_STRIKE: begin
				q_data.op = bad_prime ? OP_IGNORE : OP_STRIKE;
			end
			CMD_QUERY: begin
				q_data.op = bad_offset ? OP_BADQ : OP_QUERY;
			end
			default: begin
				q_data.op = OP_NOP;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/ssm_back.sv =====
`default_nettype none

module ssm_back #(
	parameter int SEG_SIZE = ssm_pkg::SEG_SIZE_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ssm_pkg::win_t  win,
	input  wire logic           q_empty,
	input  wire ssm_pkg::work_t q_data,
	output logic                q_pop,
	input  wire logic           out_full,
	output logic                out_push,
	output ssm_pkg::res_t       out_data
);

	import ssm_pkg::*;

	localparam int IDX_W = $clog2(SEG_SIZE);
	localparam int KW    = ((IDX_W + 1 > ROOT_W + 1) ? IDX_W + 1 : ROOT_W + 1) + 1;
	localparam logic [31:0]      SEG_SIZE_W = 32'(SEG_SIZE);
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(SEG_SIZE - 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_INIT  = 3'd1;
	localparam logic [2:0] S_DIV   = 3'd2;
	localparam logic [2:0] S_START = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_READ  = 3'd5;
	localparam logic [2:0] S_QRES  = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]        state_q;
	logic [2:0]        state_d;
	logic              init_seen_q;
	logic [TOP_W-1:0]  operand_q;
	logic [ROOT_W-1:0] p_q;
	logic [TOP_W-1:0]  div_q;
	logic [ROOT_W-1:0] rem_q;
	logic [4:0]        cnt_q;
	logic [KW-1:0]     k_q;
	logic [IDX_W-1:0]  idx_q;
	logic              rd_q;
	res_t              res_q;
	logic              mark_q [SEG_SIZE];

	logic [ROOT_W:0]   rem_sh;
	logic              rem_ge;
	logic [ROOT_W-1:0] rem_nx;
	logic [ROOT_W:0]   two_p;
	logic              low_lt;
	logic [KW-1:0]     k_start;
	logic              k_in;
	logic [TOP_W-1:0]  q_number;
	logic              mem_we;
	logic              mem_wd;
	logic [IDX_W-1:0]  mem_addr;

	assign q_pop    = (state_q == S_IDLE) && !q_empty;
	assign out_push = (state_q == S_DONE) && !out_full;
	assign out_data = res_q;

	// One restoring step of low mod p.
	assign rem_sh = {rem_q, div_q[TOP_W-1]};
	assign rem_ge = rem_sh >= {1'b0, p_q};
	assign rem_nx = rem_ge ? ROOT_W'(rem_sh - {1'b0, p_q}) : rem_sh[ROOT_W-1:0];

	// First offset to strike: 2p when the window starts below it, else the
	// first multiple of p at or past the window's low end.
	assign two_p  = {p_q, 1'b0};
	assign low_lt = win.low < TOP_W'(two_p);
	always_comb begin
		if (low_lt) begin
			k_start = KW'(two_p - win.low[ROOT_W:0]);
		end else if (rem_q == '0) begin
			k_start = '0;
		end else begin
			k_start = KW'(p_q - rem_q);
		end
	end

	// The walk stays inside the window and inside the store.
	assign k_in = (TOP_W'(k_q) <= win.span_m1) && (32'(k_q) < SEG_SIZE_W);

	assign q_number = win.low + operand_q;

	// Mark store port.
	always_comb begin
		mem_we   = 1'b0;
		mem_wd   = 1'b0;
		mem_addr = operand_q[IDX_W-1:0];
		unique case (state_q)
			S_INIT: begin
				mem_we   = 1'b1;
				mem_wd   = 1'b1;
				mem_addr = idx_q;
			end
			S_WALK: begin
				mem_we   = k_in;
				mem_addr = k_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mark_q[mem_addr] <= mem_wd;
		end
		rd_q <= mark_q[mem_addr];
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					unique case (q_data.op)
						OP_INIT:   state_d = S_INIT;
						OP_STRIKE: state_d = S_DIV;
						OP_QUERY:  state_d = S_READ;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_INIT: begin
				if (idx_q == IDX_LAST) begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (cnt_q == '0) begin
					state_d = S_START;
				end
			end
			S_START: begin
				state_d = S_WALK;
			end
			S_WALK: begin
				if (!k_in) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				state_d = S_QRES;
			end
			S_QRES: begin
				state_d = S_DONE;
			end
			default: begin
				if (!out_full) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// Control state; the init flag gates marks that were never filled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			init_seen_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == S_INIT) && (idx_q == IDX_LAST)) begin
				init_seen_q <= 1'b1;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				operand_q      <= q_data.operand;
				p_q            <= q_data.operand[ROOT_W-1:0];
				div_q          <= win.low;
				rem_q          <= '0;
				cnt_q          <= 5'(TOP_W - 1);
				idx_q          <= '0;
				res_q.number   <= '0;
				res_q.is_prime <= 1'b0;
				if (q_data.op == OP_IGNORE) begin
					res_q.status <= STAT_IGNORED;
				end else if (q_data.op == OP_BADQ) begin
					res_q.status <= STAT_RANGE;
				end else begin
					res_q.status <= STAT_DONE;
				end
			end
			S_INIT: begin
				idx_q <= idx_q + 1'b1;
			end
			S_DIV: begin
				rem_q <= rem_nx;
				div_q <= {div_q[TOP_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			S_START: begin
				k_q <= k_start;
			end
			S_WALK: begin
				k_q <= k_q + KW'(p_q);
			end
			S_QRES: begin
				res_q.number   <= q_number;
				res_q.is_prime <= init_seen_q && rd_q && (q_number > TOP_W'(1));
				res_q.status   <= STAT_DONE;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/ssm_checker.sv =====
`default_nettype none
`include "segmented_sieve_marker_top_defines.svh"

module ssm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          pop,
	input wire logic                          empty,
	input wire logic [ssm_pkg::TOP_W-1:0]     number,
	input wire logic                          is_prime,
	input wire logic [ssm_pkg::STAT_W-1:0]    status
);

	import ssm_pkg::*;

	// A result that is not a completed query carries no number and no prime flag.
	`SSM_ASSERT_IMP(a_fail_zero, clk, arst_n,
		!empty && (status != STAT_DONE), (number == '0) && !is_prime)

	// A prime flag is only shown for a completed query of a number above one.
	`SSM_ASSERT_IMP(a_prime_num, clk, arst_n,
		!empty && is_prime, (status == STAT_DONE) && (number > 31'd1))

	// An unpopped result stays in place.
	`SSM_ASSERT_NXT(a_res_hold, clk, arst_n, !empty && !pop,
		!empty && $stable(number) && $stable(status) && $stable(is_prime))

endmodule

bind segmented_sieve_marker_top ssm_checker u_ssm_checker (.*);

`default_nettype wire
